// ===== src/lbvs_pkg.sv =====
// Shared constants, types and saturation helper for the vertex skinning block.
package lbvs_pkg;

  // Palette geometry and fixed-point formats
  localparam int MAX_BONES      = 64;
  localparam int INFLUENCES     = 4;
  localparam int FRAC_BITS      = 16;
  localparam int WEIGHT_FRAC    = 15;
  localparam int WORDS_PER_BONE = 12;
  localparam int PALETTE_DEPTH  = MAX_BONES * WORDS_PER_BONE;
  localparam int BONE_AW        = $clog2(MAX_BONES);

  // Field widths, fixed by the stream format
  localparam int SLOTS  = 4;   // influence slots carried in one vertex beat
  localparam int IDX_W  = 6;
  localparam int WGT_W  = 16;
  localparam int WORD_W = 32;
  localparam int ADDR_W = 10;
  localparam int ELEM_W = 4;

  // Input tdata layout, lowest bit first
  localparam int ADDR_LSB    = 0;
  localparam int VALUE_LSB   = ADDR_LSB + ADDR_W;
  localparam int VEC_LSB     = VALUE_LSB + WORD_W;     // pos x,y,z then norm x,y,z
  localparam int BONES_LSB   = VEC_LSB + 6 * WORD_W;
  localparam int WEIGHTS_LSB = BONES_LSB + SLOTS * IDX_W;
  localparam int IN_USED_W   = WEIGHTS_LSB + SLOTS * WGT_W;
  localparam int IN_DATA_W   = ((IN_USED_W + 7) / 8) * 8;
  localparam int OUT_DATA_W  = 6 * WORD_W;

  // Datapath widths
  localparam int PROD_W   = WORD_W + WGT_W + 1;   // palette word times weight
  localparam int PAIR_W   = PROD_W + 1;
  localparam int BLEND_W  = PAIR_W + 1;
  localparam int XPROD_W  = 2 * WORD_W;
  localparam int SUM_W    = XPROD_W + 3;
  localparam int SAT_IN_W = 72;

  localparam int PIPE_STAGES = 7;

  localparam logic signed [BLEND_W-1:0] BL_ROUND = BLEND_W'(1) << (WEIGHT_FRAC - 1);
  localparam logic signed [SUM_W-1:0]   XF_ROUND = SUM_W'(1) << (FRAC_BITS - 1);

  localparam logic signed [SAT_IN_W-1:0] SAT_HI =
    SAT_IN_W'((64'sd1 <<< (WORD_W - 1)) - 64'sd1);
  localparam logic signed [SAT_IN_W-1:0] SAT_LO = -SAT_HI - SAT_IN_W'(1);
  localparam logic signed [WORD_W-1:0]   WORD_MAX = SAT_HI[WORD_W-1:0];
  localparam logic signed [WORD_W-1:0]   WORD_MIN = SAT_LO[WORD_W-1:0];

  typedef enum logic {
    KIND_WRITE  = 1'b0,
    KIND_VERTEX = 1'b1
  } kind_e;

  // Clamp a wide signed value to a 32-bit signed word
  function automatic logic signed [WORD_W-1:0] sat32_f(input logic signed [SAT_IN_W-1:0] x);
    logic signed [WORD_W-1:0] r;
    if (x > SAT_HI) begin
      r = WORD_MAX;
    end else if (x < SAT_LO) begin
      r = WORD_MIN;
    end else begin
      r = x[WORD_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== src/lbvs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module lbvs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/linear_blend_vertex_skinning.sv =====
// Linear blend skinning engine: bone palette memories and blend/transform pipeline.
//
//  channel  | dir | beat contents
//  ---------+-----+---------------------------------------------------------------
//  s_axis   | in  | tuser = kind; tdata = palette write or vertex (pos, norm, bones, wts)
//  m_axis   | out | tdata = skinned pos x,y,z and normal x,y,z, one beat per vertex
//
//  One beat per clock in either direction while no clear runs and m_axis does not stall.
//  A vertex passes every stage register in turn; a palette write gives no output beat.
//  The palette sits in 12 x 4 RAMs of 64 words (one element column per influence slot),
//  so all four bone matrices of a vertex are read in the single accept cycle.
//  After reset a clearing pass zeroes all 64 palette rows; s_axis_tready_o is low then.
//  Each of the 7 stages has its own valid bit; a stall on m_axis fills bubbles first
//  and reaches s_axis_tready_o only once every stage holds a vertex.
module linear_blend_vertex_skinning import lbvs_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // palette_addr, palette_value, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z,
  // bone_ids, weights, zero pad
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // kind
  input  logic [0:0]            s_axis_tuser_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // out_pos_x, out_pos_y, out_pos_z, out_norm_x, out_norm_y, out_norm_z
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o
);

  // ---------------------------------------------------------------------------
  // Input field split
  // ---------------------------------------------------------------------------
  kind_e              in_kind;
  logic [ADDR_W-1:0]  in_addr;
  logic [WORD_W-1:0]  in_value;
  logic [WORD_W-1:0]  in_vec [6];
  logic [IDX_W-1:0]   in_bone [SLOTS];
  logic [WGT_W-1:0]   in_wgt [SLOTS];

  assign in_kind  = kind_e'(s_axis_tuser_i[0]);
  assign in_addr  = s_axis_tdata_i[ADDR_LSB +: ADDR_W];
  assign in_value = s_axis_tdata_i[VALUE_LSB +: WORD_W];

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      in_vec[i] = s_axis_tdata_i[VEC_LSB + i * WORD_W +: WORD_W];
    end
    for (int k = 0; k < SLOTS; k++) begin
      in_bone[k] = s_axis_tdata_i[BONES_LSB + k * IDX_W +: IDX_W];
      in_wgt[k]  = s_axis_tdata_i[WEIGHTS_LSB + k * WGT_W +: WGT_W];
    end
  end

  // ---------------------------------------------------------------------------
  // Handshake, stage enables and reset clearing pass
  // ---------------------------------------------------------------------------
  logic [PIPE_STAGES-1:0] valid_q;
  logic [PIPE_STAGES-1:0] en;
  logic                   clearing_q;
  logic [BONE_AW-1:0]     clr_cnt_q;
  logic                   in_fire;
  logic                   wr_fire;
  logic                   vx_fire;

  always_comb begin
    en[PIPE_STAGES-1] = !valid_q[PIPE_STAGES-1] || m_axis_tready_i;
    for (int i = PIPE_STAGES - 2; i >= 0; i--) begin
      en[i] = !valid_q[i] || en[i+1];
    end
  end

  assign s_axis_tready_o = !clearing_q && en[0];
  assign in_fire = s_axis_tvalid_i && s_axis_tready_o;
  assign wr_fire = in_fire && (in_kind == KIND_WRITE);
  assign vx_fire = in_fire && (in_kind == KIND_VERTEX);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clearing_q) begin
      clr_cnt_q <= clr_cnt_q + BONE_AW'(1);
      if (clr_cnt_q == BONE_AW'(MAX_BONES - 1)) begin
        clearing_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[0]) begin
        valid_q[0] <= vx_fire;
      end
      for (int i = 1; i < PIPE_STAGES; i++) begin
        if (en[i]) begin
          valid_q[i] <= valid_q[i-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Palette write decode: addr = bone*12 + elem
  // bone = (addr/4)/3, with /3 done as *171 >> 9 (exact for 8-bit values)
  // ---------------------------------------------------------------------------
  logic [15:0]        div3_prod;
  logic [6:0]         wr_bone;
  logic [ADDR_W-1:0]  wr_base;
  logic [ADDR_W-1:0]  wr_rem;
  logic [ELEM_W-1:0]  wr_elem;
  logic               wr_in_range;

  assign div3_prod   = 16'(in_addr[ADDR_W-1:2]) * 16'd171;
  assign wr_bone     = div3_prod[15:9];
  assign wr_base     = ADDR_W'({wr_bone, 3'b000}) + ADDR_W'({wr_bone, 2'b00});
  assign wr_rem      = in_addr - wr_base;
  assign wr_elem     = wr_rem[ELEM_W-1:0];
  assign wr_in_range = {22'd0, in_addr} < 32'(PALETTE_DEPTH);

  // ---------------------------------------------------------------------------
  // Palette memories: one per (influence slot, element); writes go to all slots
  // ---------------------------------------------------------------------------
  logic [WORDS_PER_BONE-1:0] ram_we;
  logic [BONE_AW-1:0]        ram_waddr;
  logic [WORD_W-1:0]         ram_wdata;
  logic [BONE_AW-1:0]        ram_raddr [SLOTS];
  logic [WORD_W-1:0]         ram_rdata [SLOTS][WORDS_PER_BONE];

  always_comb begin
    for (int e = 0; e < WORDS_PER_BONE; e++) begin
      ram_we[e] = clearing_q || (wr_fire && wr_in_range && (wr_elem == ELEM_W'(e)));
    end
    for (int k = 0; k < SLOTS; k++) begin
      ram_raddr[k] = in_bone[k][BONE_AW-1:0];
    end
  end

  assign ram_waddr = clearing_q ? clr_cnt_q : wr_bone[BONE_AW-1:0];
  assign ram_wdata = clearing_q ? '0 : in_value;

  for (genvar k = 0; k < SLOTS; k++) begin : g_slot
    for (genvar e = 0; e < WORDS_PER_BONE; e++) begin : g_elem
      lbvs_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_BONES)
      ) u_ram (
        .clk_i   (clk_i),
        .we_i    (ram_we[e]),
        .waddr_i (ram_waddr),
        .wdata_i (ram_wdata),
        .re_i    (vx_fire),
        .raddr_i (ram_raddr[k]),
        .rdata_o (ram_rdata[k][e])
      );
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: side data beside the RAM read. Unused slots and bones past the
  // palette get a zero weight, which makes them an all-zero matrix.
  // ---------------------------------------------------------------------------
  logic [WGT_W-1:0]  w1_d [SLOTS];
  logic [WGT_W-1:0]  w1_q [SLOTS];
  logic [WORD_W-1:0] vec1_q [6];
  logic [WORD_W-1:0] vec2_q [6];
  logic [WORD_W-1:0] vec3_q [6];
  logic [WORD_W-1:0] vec4_q [6];

  always_comb begin
    for (int k = 0; k < SLOTS; k++) begin
      w1_d[k] = ((k < INFLUENCES) && ({26'd0, in_bone[k]} < 32'(MAX_BONES))) ?
                in_wgt[k] : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vx_fire) begin
      w1_q   <= w1_d;
      vec1_q <= in_vec;
    end
    if (en[1]) vec2_q <= vec1_q;
    if (en[2]) vec3_q <= vec2_q;
    if (en[3]) vec4_q <= vec3_q;
  end

  // ---------------------------------------------------------------------------
  // Stage 2: word * weight products (32s x 16u)
  // ---------------------------------------------------------------------------
  logic signed [PROD_W-1:0] prod_d [SLOTS][WORDS_PER_BONE];
  logic signed [PROD_W-1:0] prod_q [SLOTS][WORDS_PER_BONE];

  always_comb begin
    for (int k = 0; k < SLOTS; k++) begin
      for (int e = 0; e < WORDS_PER_BONE; e++) begin
        prod_d[k][e] = PROD_W'($signed(ram_rdata[k][e])) *
                       PROD_W'($signed({1'b0, w1_q[k]}));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) prod_q <= prod_d;
  end

  // ---------------------------------------------------------------------------
  // Stage 3: pair sums of influences 0+1 and 2+3
  // ---------------------------------------------------------------------------
  logic signed [PAIR_W-1:0] pair_d [2][WORDS_PER_BONE];
  logic signed [PAIR_W-1:0] pair_q [2][WORDS_PER_BONE];

  always_comb begin
    for (int j = 0; j < 2; j++) begin
      for (int e = 0; e < WORDS_PER_BONE; e++) begin
        pair_d[j][e] = PAIR_W'(prod_q[2*j][e]) + PAIR_W'(prod_q[2*j+1][e]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) pair_q <= pair_d;
  end

  // ---------------------------------------------------------------------------
  // Stage 4: blended matrix, rounded half up to Q16.16 and clamped
  // ---------------------------------------------------------------------------
  logic signed [BLEND_W-1:0] bl_acc [WORDS_PER_BONE];
  logic signed [WORD_W-1:0]  blend_d [WORDS_PER_BONE];
  logic signed [WORD_W-1:0]  blend_q [WORDS_PER_BONE];

  always_comb begin
    for (int e = 0; e < WORDS_PER_BONE; e++) begin
      bl_acc[e]  = BLEND_W'(pair_q[0][e]) + BLEND_W'(pair_q[1][e]) + BL_ROUND;
      blend_d[e] = sat32_f(SAT_IN_W'(bl_acc[e] >>> WEIGHT_FRAC));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) blend_q <= blend_d;
  end

  // ---------------------------------------------------------------------------
  // Stage 5: row x vector products for position and normal
  // ---------------------------------------------------------------------------
  logic signed [XPROD_W-1:0] xp_pos_d [3][3];
  logic signed [XPROD_W-1:0] xp_nrm_d [3][3];
  logic signed [XPROD_W-1:0] xp_pos_q [3][3];
  logic signed [XPROD_W-1:0] xp_nrm_q [3][3];
  logic signed [WORD_W-1:0]  offs_q [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int j = 0; j < 3; j++) begin
        xp_pos_d[r][j] = XPROD_W'(blend_q[r*4+j]) * XPROD_W'($signed(vec4_q[j]));
        xp_nrm_d[r][j] = XPROD_W'(blend_q[r*4+j]) * XPROD_W'($signed(vec4_q[3+j]));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      xp_pos_q <= xp_pos_d;
      xp_nrm_q <= xp_nrm_d;
      for (int r = 0; r < 3; r++) begin
        offs_q[r] <= blend_q[r*4+3];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 6: partial sums; translation and rounding folded into one half
  // ---------------------------------------------------------------------------
  logic signed [SUM_W-1:0] pa_d [3];
  logic signed [SUM_W-1:0] pb_d [3];
  logic signed [SUM_W-1:0] na_d [3];
  logic signed [SUM_W-1:0] nb_d [3];
  logic signed [SUM_W-1:0] pa_q [3];
  logic signed [SUM_W-1:0] pb_q [3];
  logic signed [SUM_W-1:0] na_q [3];
  logic signed [SUM_W-1:0] nb_q [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      pa_d[r] = SUM_W'(xp_pos_q[r][0]) + SUM_W'(xp_pos_q[r][1]);
      pb_d[r] = SUM_W'(xp_pos_q[r][2]) + (SUM_W'(offs_q[r]) <<< FRAC_BITS) + XF_ROUND;
      na_d[r] = SUM_W'(xp_nrm_q[r][0]) + SUM_W'(xp_nrm_q[r][1]);
      nb_d[r] = SUM_W'(xp_nrm_q[r][2]) + XF_ROUND;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      pa_q <= pa_d;
      pb_q <= pb_d;
      na_q <= na_d;
      nb_q <= nb_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 7: final sum, shift to Q16.16, clamp; this is the output register
  // ---------------------------------------------------------------------------
  logic signed [SUM_W-1:0]  ptot [3];
  logic signed [SUM_W-1:0]  ntot [3];
  logic signed [WORD_W-1:0] out_d [6];
  logic signed [WORD_W-1:0] out_q [6];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      ptot[r]    = pa_q[r] + pb_q[r];
      ntot[r]    = na_q[r] + nb_q[r];
      out_d[r]   = sat32_f(SAT_IN_W'(ptot[r] >>> FRAC_BITS));
      out_d[3+r] = sat32_f(SAT_IN_W'(ntot[r] >>> FRAC_BITS));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[6]) out_q <= out_d;
  end

  assign m_axis_tvalid_o = valid_q[PIPE_STAGES-1];

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      m_axis_tdata_o[i * WORD_W +: WORD_W] = out_q[i];
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // Nothing is taken on s_axis while the palette is being cleared.
  a_no_accept_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing_q |-> !in_fire)
    else $error("beat accepted during palette clear");

  // The clearing pass ends exactly after the last palette row.
  a_clear_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(clearing_q) |-> $past(clr_cnt_q) == BONE_AW'(MAX_BONES - 1))
    else $error("palette clear ended early");

  // An accepted vertex always lands in stage 1.
  a_vertex_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vx_fire |=> valid_q[0])
    else $error("accepted vertex lost at stage 1");

  // Stage 4 (valid_q[3]), when it is held, keeps its vertex.
  a_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q[3] && !en[3]) |=> valid_q[3])
    else $error("held stage dropped its vertex");

  // A write beat never enters the pipeline.
  a_write_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_fire && !valid_q[0]) |=> !valid_q[0])
    else $error("palette write produced a pipeline entry");

endmodule
